### src/rtc_bcd_datetime_codec_macros.svh
// assertion macros for the bcd rtc date/time codec
`ifndef RTC_BCD_DATETIME_CODEC_MACROS_SVH
`define RTC_BCD_DATETIME_CODEC_MACROS_SVH

// same-cycle implication, checked out of reset
`define RTCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtcc assertion failed");

// next-cycle implication, checked out of reset
`define RTCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtcc assertion failed");

`endif

### src/rtcc_pkg.sv
// types, constants and helper functions of the bcd rtc date/time codec
`default_nettype none

package rtcc_pkg;

	localparam int STAGES = 3;

	typedef enum logic {
		KIND_DECODE = 1'b0,
		KIND_ENCODE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [55:0] raw_regs;
		logic [7:0]  set_seconds;
		logic [7:0]  set_minutes;
		logic [7:0]  set_hours;
		logic [7:0]  set_weekday;
		logic [7:0]  set_day;
		logic [7:0]  set_month;
		logic [15:0] set_year;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [6:0]  got_seconds;
		logic [6:0]  got_minutes;
		logic [5:0]  got_hours;
		logic [2:0]  got_weekday;
		logic [5:0]  got_day;
		logic [4:0]  got_month;
		logic [11:0] got_year;
		logic [55:0] encoded_regs;
	} rsp_t;

	typedef struct packed {
		logic              req_ready;
		logic [STAGES-1:0] load;
		logic [STAGES-1:0] valid;
	} pipe_ctl_t;

	localparam logic [7:0]  SEC_MAX       = 8'd59;
	localparam logic [7:0]  MIN_MAX       = 8'd59;
	localparam logic [7:0]  HOUR_MAX      = 8'd23;
	localparam logic [7:0]  WDAY_MIN      = 8'd1;
	localparam logic [7:0]  WDAY_MAX      = 8'd7;
	localparam logic [7:0]  DAY_MIN       = 8'd1;
	localparam logic [7:0]  DAY_MAX       = 8'd31;
	localparam logic [7:0]  MONTH_MIN     = 8'd1;
	localparam logic [7:0]  MONTH_MAX     = 8'd12;
	localparam logic [15:0] YEAR_MIN      = 16'd2000;
	localparam logic [15:0] YEAR_MAX      = 16'd2199;
	localparam logic [11:0] YEAR_BASE     = 12'd2000;
	localparam logic [11:0] CENTURY_YEARS = 12'd100;
	localparam logic [7:0]  CENTURY_OFF   = 8'd100;
	localparam logic [4:0]  HALF_DAY      = 5'd12;
	localparam logic [4:0]  FULL_DAY      = 5'd24;
	localparam logic [5:0]  PM_OFFSET     = 6'd12;
	localparam logic [7:0]  CENTURY_BIT   = 8'h80;
	localparam logic [13:0] RECIP_TEN     = 14'd103;

	// high nibble * 10 + low nibble, digits not checked
	function automatic logic [7:0] bcd_in(input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = b[7:4];
		lo = b[3:0];
		return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
	endfunction

	// two bcd digits of a value below 100, tens by reciprocal multiply
	function automatic logic [7:0] bcd_byte(input logic [6:0] v);
		logic [13:0] prod;
		logic [3:0]  q;
		logic [6:0]  tens;
		logic [6:0]  rem;
		prod = {7'b0000000, v} * RECIP_TEN;
		q    = prod[13:10];
		tens = {q, 3'b000} + {2'b00, q, 1'b0};
		rem  = v - tens;
		return {q, rem[3:0]};
	endfunction

endpackage

`default_nettype wire

### src/rtcc_pipe_ctl.sv
// valid/ready control of the codec pipeline: stage valid bits and load enables
`default_nettype none

module rtcc_pipe_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                rsp_ready,
	output rtcc_pkg::pipe_ctl_t ctl
);

	localparam int N = rtcc_pkg::STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] ready;
	logic [N-1:0] upstream;

	always_comb begin
		ready[N-1] = !valid_q[N-1] || rsp_ready;
		for (int i = N - 2; i >= 0; i--) begin
			ready[i] = !valid_q[i] || ready[i+1];
		end
		upstream[0] = req_valid;
		for (int i = 1; i < N; i++) begin
			upstream[i] = valid_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (ready[i]) begin
					valid_q[i] <= upstream[i];
				end
			end
		end
	end

	assign ctl.req_ready = ready[0];
	assign ctl.load      = ready & upstream;
	assign ctl.valid     = valid_q;

endmodule

`default_nettype wire

### src/rtc_bcd_datetime_codec.sv
// top level of the bcd rtc date/time codec: three-stage decode/encode pipeline
//
//   channel | signals                      | beat
//   --------+------------------------------+--------------------------------------
//   req     | req_valid, req_ready, req    | kind, raw register bytes, set_* fields
//   rsp     | rsp_valid, rsp_ready, rsp    | accepted, got_* fields, encoded bytes
//
// a beat is registered in stages 1, 2 and 3 in order; one beat per cycle sustained while rsp_ready is high
// stage 1 registers the beat, stage 2 holds digit sums and range checks,
// stage 3 holds the finished result and drives rsp
// a stalled rsp holds stage 3; earlier stages keep filling bubbles, then stop
// reset empties all stages; payload registers are not reset
`default_nettype none

module rtc_bcd_datetime_codec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rtcc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rtcc_pkg::rsp_t rsp
);

	rtcc_pkg::pipe_ctl_t ctl;

	rtcc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	assign req_ready = ctl.req_ready;
	assign rsp_valid = ctl.valid[2];

	// stage 1
	rtcc_pkg::req_t req_s1;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			req_s1 <= req;
		end
	end

	// stage 2 datapath
	logic [7:0] b0, b1, b2, b3, b4, b5, b6;
	logic [7:0] d_sec_w, d_min_w, d_h12_w, d_h24_w, d_day_w, d_mon_w, d_yr_w;
	logic [15:0] off_w;
	logic       e_cent_w;
	logic [7:0] yoff_w;
	logic       ok_w;

	assign b0 = req_s1.raw_regs[7:0];
	assign b1 = req_s1.raw_regs[15:8];
	assign b2 = req_s1.raw_regs[23:16];
	assign b3 = req_s1.raw_regs[31:24];
	assign b4 = req_s1.raw_regs[39:32];
	assign b5 = req_s1.raw_regs[47:40];
	assign b6 = req_s1.raw_regs[55:48];

	always_comb begin
		d_sec_w  = rtcc_pkg::bcd_in({1'b0, b0[6:0]});
		d_min_w  = rtcc_pkg::bcd_in({1'b0, b1[6:0]});
		d_h12_w  = rtcc_pkg::bcd_in({3'b000, b2[4:0]});
		d_h24_w  = rtcc_pkg::bcd_in({2'b00, b2[5:0]});
		d_day_w  = rtcc_pkg::bcd_in({2'b00, b4[5:0]});
		d_mon_w  = rtcc_pkg::bcd_in({3'b000, b5[4:0]});
		d_yr_w   = rtcc_pkg::bcd_in(b6);
		ok_w = (req_s1.set_seconds <= rtcc_pkg::SEC_MAX) &&
			(req_s1.set_minutes <= rtcc_pkg::MIN_MAX) &&
			(req_s1.set_hours <= rtcc_pkg::HOUR_MAX) &&
			(req_s1.set_weekday >= rtcc_pkg::WDAY_MIN) &&
			(req_s1.set_weekday <= rtcc_pkg::WDAY_MAX) &&
			(req_s1.set_day >= rtcc_pkg::DAY_MIN) &&
			(req_s1.set_day <= rtcc_pkg::DAY_MAX) &&
			(req_s1.set_month >= rtcc_pkg::MONTH_MIN) &&
			(req_s1.set_month <= rtcc_pkg::MONTH_MAX) &&
			(req_s1.set_year >= rtcc_pkg::YEAR_MIN) &&
			(req_s1.set_year <= rtcc_pkg::YEAR_MAX);
		off_w    = req_s1.set_year - rtcc_pkg::YEAR_MIN;
		e_cent_w = off_w[7:0] >= rtcc_pkg::CENTURY_OFF;
		yoff_w   = e_cent_w ? (off_w[7:0] - rtcc_pkg::CENTURY_OFF) : off_w[7:0];
	end

	rtcc_pkg::kind_t kind_s2;
	logic       ok_s2, e_cent_s2, mode12_s2, pm_s2, d_cent_s2;
	logic [6:0] d_sec_s2, d_min_s2;
	logic [4:0] d_h12_s2, d_mon_s2;
	logic [5:0] d_h24_s2, d_day_s2;
	logic [2:0] d_wd_s2;
	logic [7:0] d_yr_s2;
	logic [6:0] e_sec_s2, e_min_s2, e_hr_s2, e_wd_s2, e_day_s2, e_mon_s2, e_yoff_s2;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			kind_s2   <= req_s1.kind;
			ok_s2     <= ok_w;
			e_cent_s2 <= e_cent_w;
			mode12_s2 <= b2[6];
			pm_s2     <= b2[5];
			d_cent_s2 <= b5[7];
			d_sec_s2  <= d_sec_w[6:0];
			d_min_s2  <= d_min_w[6:0];
			d_h12_s2  <= d_h12_w[4:0];
			d_h24_s2  <= d_h24_w[5:0];
			d_wd_s2   <= b3[2:0];
			d_day_s2  <= d_day_w[5:0];
			d_mon_s2  <= d_mon_w[4:0];
			d_yr_s2   <= d_yr_w;
			e_sec_s2  <= req_s1.set_seconds[6:0];
			e_min_s2  <= req_s1.set_minutes[6:0];
			e_hr_s2   <= req_s1.set_hours[6:0];
			e_wd_s2   <= req_s1.set_weekday[6:0];
			e_day_s2  <= req_s1.set_day[6:0];
			e_mon_s2  <= req_s1.set_month[6:0];
			e_yoff_s2 <= yoff_w[6:0];
		end
	end

	// stage 3 datapath
	logic [4:0]     hmod_w;
	logic [5:0]     hours_w;
	logic [7:0]     mon_byte_w;
	rtcc_pkg::rsp_t rsp_w;

	always_comb begin
		if (d_h12_s2 >= rtcc_pkg::FULL_DAY) begin
			hmod_w = d_h12_s2 - rtcc_pkg::FULL_DAY;
		end else if (d_h12_s2 >= rtcc_pkg::HALF_DAY) begin
			hmod_w = d_h12_s2 - rtcc_pkg::HALF_DAY;
		end else begin
			hmod_w = d_h12_s2;
		end
		if (mode12_s2) begin
			hours_w = pm_s2 ? ({1'b0, hmod_w} + rtcc_pkg::PM_OFFSET) : {1'b0, hmod_w};
		end else begin
			hours_w = d_h24_s2;
		end
		mon_byte_w = rtcc_pkg::bcd_byte(e_mon_s2) |
			(e_cent_s2 ? rtcc_pkg::CENTURY_BIT : 8'h00);

		rsp_w = '0;
		case (kind_s2)
			rtcc_pkg::KIND_DECODE: begin
				rsp_w.accepted    = 1'b1;
				rsp_w.got_seconds = d_sec_s2;
				rsp_w.got_minutes = d_min_s2;
				rsp_w.got_hours   = hours_w;
				rsp_w.got_weekday = d_wd_s2;
				rsp_w.got_day     = d_day_s2;
				rsp_w.got_month   = d_mon_s2;
				rsp_w.got_year    = rtcc_pkg::YEAR_BASE + {4'b0000, d_yr_s2} +
					(d_cent_s2 ? rtcc_pkg::CENTURY_YEARS : 12'd0);
			end
			rtcc_pkg::KIND_ENCODE: begin
				rsp_w.accepted = ok_s2;
				if (ok_s2) begin
					rsp_w.encoded_regs = {
						rtcc_pkg::bcd_byte(e_yoff_s2),
						mon_byte_w,
						rtcc_pkg::bcd_byte(e_day_s2),
						rtcc_pkg::bcd_byte(e_wd_s2),
						rtcc_pkg::bcd_byte(e_hr_s2),
						rtcc_pkg::bcd_byte(e_min_s2),
						rtcc_pkg::bcd_byte(e_sec_s2)
					};
				end
			end
			default: begin
				rsp_w = '0;
			end
		endcase
	end

	rtcc_pkg::rsp_t rsp_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			rsp_s3 <= rsp_w;
		end
	end

	assign rsp = rsp_s3;

`include "rtc_bcd_datetime_codec_macros.svh"

	// empty output stage means the whole ready chain is open
	`RTCC_ASSERT_IMPL(a_empty_takes_req, !rsp_valid, req_ready)
	// an output that is free to drain lets a new beat in
	`RTCC_ASSERT_IMPL(a_drain_takes_req, rsp_ready, req_ready)
	// encoded bytes only come with an accepted encode, which carries no decoded year
	`RTCC_ASSERT_IMPL(a_enc_only_ok, rsp_valid && (rsp.encoded_regs != '0), rsp.accepted && (rsp.got_year == '0))

endmodule

`default_nettype wire

### verif/tb_top.sv
// testbench for the bcd rtc date/time codec: directed and random beats checked against a predictor
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          PHASE_ITEMS  = 517;
	localparam int          DRAIN_CYCLES = 8;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	rtcc_pkg::req_t req       = '0;
	logic           req_ready;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	rtcc_pkg::rsp_t rsp;

	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             error_count   = 0;
	int unsigned    cycle_count   = 0;
	rtcc_pkg::rsp_t pending_results[$];

	rtc_bcd_datetime_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int unsigned bcd_value(input logic [7:0] b);
		int unsigned hi;
		int unsigned lo;
		hi = int'(b[7:4]);
		lo = int'(b[3:0]);
		return hi * 10 + lo;
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		int unsigned tens;
		int unsigned ones;
		tens = (v / 10) % 16;
		ones = v % 10;
		return {tens[3:0], ones[3:0]};
	endfunction

	function automatic rtcc_pkg::rsp_t predict_datetime(input rtcc_pkg::req_t r);
		rtcc_pkg::rsp_t res;
		logic [7:0]     b [7];
		int unsigned    hrs;
		int unsigned    year;
		int unsigned    v;
		int unsigned    yr_off;
		logic [7:0]     month_byte;
		logic           ok;
		res = '0;
		if (r.kind == rtcc_pkg::KIND_DECODE) begin
			for (int i = 0; i < 7; i++)
				b[i] = r.raw_regs[8*i +: 8];
			if (b[2][6]) begin
				hrs = bcd_value(b[2] & 8'h1F) % 12;
				if (b[2][5])
					hrs = hrs + 12;
			end else begin
				hrs = bcd_value(b[2] & 8'h3F);
			end
			year = 2000 + bcd_value(b[6]) + (b[5][7] ? 100 : 0);
			res.accepted = 1'b1;
			v = bcd_value(b[0] & 8'h7F);
			res.got_seconds = v[6:0];
			v = bcd_value(b[1] & 8'h7F);
			res.got_minutes = v[6:0];
			res.got_hours = hrs[5:0];
			v = bcd_value(b[3] & 8'h07);
			res.got_weekday = v[2:0];
			v = bcd_value(b[4] & 8'h3F);
			res.got_day = v[5:0];
			v = bcd_value(b[5] & 8'h1F);
			res.got_month = v[4:0];
			res.got_year = year[11:0];
		end else begin
			ok = (r.set_seconds <= 8'd59) && (r.set_minutes <= 8'd59) &&
				(r.set_hours <= 8'd23) &&
				(r.set_weekday >= 8'd1) && (r.set_weekday <= 8'd7) &&
				(r.set_day >= 8'd1) && (r.set_day <= 8'd31) &&
				(r.set_month >= 8'd1) && (r.set_month <= 8'd12) &&
				(r.set_year >= 16'd2000) && (r.set_year <= 16'd2199);
			if (ok) begin
				yr_off = int'(r.set_year) - 2000;
				month_byte = to_bcd(int'(r.set_month));
				if (yr_off >= 100)
					month_byte[7] = 1'b1;
				res.accepted = 1'b1;
				res.encoded_regs = {to_bcd(yr_off % 100), month_byte,
					to_bcd(int'(r.set_day)), to_bcd(int'(r.set_weekday)),
					to_bcd(int'(r.set_hours)), to_bcd(int'(r.set_minutes)),
					to_bcd(int'(r.set_seconds))};
			end
		end
		return res;
	endfunction

	function automatic logic [55:0] random_raw();
		logic [63:0] r64;
		r64 = {$urandom, $urandom};
		return r64[55:0];
	endfunction

	// fields that the kind does not use carry random noise
	function automatic rtcc_pkg::req_t decode_item(input logic [55:0] raw);
		rtcc_pkg::req_t item;
		logic [63:0]    r64;
		r64 = {$urandom, $urandom};
		item = {rtcc_pkg::KIND_ENCODE, random_raw(), r64};
		item.kind = rtcc_pkg::KIND_DECODE;
		item.raw_regs = raw;
		return item;
	endfunction

	function automatic rtcc_pkg::req_t encode_item(input logic [7:0] sec,
			input logic [7:0] mins, input logic [7:0] hr, input logic [7:0] wd,
			input logic [7:0] dy, input logic [7:0] mo, input logic [15:0] yr);
		rtcc_pkg::req_t item;
		item.kind = rtcc_pkg::KIND_ENCODE;
		item.raw_regs = random_raw();
		item.set_seconds = sec;
		item.set_minutes = mins;
		item.set_hours = hr;
		item.set_weekday = wd;
		item.set_day = dy;
		item.set_month = mo;
		item.set_year = yr;
		return item;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic check_result(input rtcc_pkg::rsp_t got);
		rtcc_pkg::rsp_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected beat", 64'(got.encoded_regs), 64'd0);
		end else begin
			want = pending_results.pop_front();
			if (got.accepted !== want.accepted)
				report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
			if (got.got_seconds !== want.got_seconds)
				report_mismatch("got_seconds", 64'(got.got_seconds),
					64'(want.got_seconds));
			if (got.got_minutes !== want.got_minutes)
				report_mismatch("got_minutes", 64'(got.got_minutes),
					64'(want.got_minutes));
			if (got.got_hours !== want.got_hours)
				report_mismatch("got_hours", 64'(got.got_hours), 64'(want.got_hours));
			if (got.got_weekday !== want.got_weekday)
				report_mismatch("got_weekday", 64'(got.got_weekday),
					64'(want.got_weekday));
			if (got.got_day !== want.got_day)
				report_mismatch("got_day", 64'(got.got_day), 64'(want.got_day));
			if (got.got_month !== want.got_month)
				report_mismatch("got_month", 64'(got.got_month), 64'(want.got_month));
			if (got.got_year !== want.got_year)
				report_mismatch("got_year", 64'(got.got_year), 64'(want.got_year));
			if (got.encoded_regs !== want.encoded_regs)
				report_mismatch("encoded_regs", 64'(got.encoded_regs),
					64'(want.encoded_regs));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_beat(input rtcc_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_results.push_back(predict_datetime(item));
	endtask

	task automatic test_decode_fields();
		send_beat(decode_item(56'h0));
		send_beat(decode_item({56{1'b1}}));
		send_beat(decode_item(56'h99_12_31_07_23_59_59));
		// century bit set
		send_beat(decode_item(56'h99_92_01_01_00_00_00));
		// non-decimal digits
		send_beat(decode_item(56'hFA_9F_3F_0F_3F_7F_7F));
	endtask

	task automatic test_twelve_hour();
		send_beat(decode_item(56'h00_01_01_01_52_00_00));
		send_beat(decode_item(56'h00_01_01_01_72_00_00));
		send_beat(decode_item(56'h00_01_01_01_71_00_00));
		send_beat(decode_item(56'h00_01_01_01_41_00_00));
		send_beat(decode_item(56'h00_01_01_01_7F_00_00));
	endtask

	task automatic test_encode_limits();
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd59, 8'd59, 8'd23, 8'd7, 8'd31, 8'd12, 16'd2199));
		send_beat(encode_item(8'd30, 8'd45, 8'd12, 8'd4, 8'd15, 8'd6, 16'd2099));
		send_beat(encode_item(8'd30, 8'd45, 8'd12, 8'd4, 8'd15, 8'd6, 16'd2100));
	endtask

	task automatic test_encode_rejects();
		send_beat(encode_item(8'd60, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd60, 8'd0, 8'd1, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd24, 8'd1, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd8, 8'd1, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd32, 8'd1, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd13, 16'd2000));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd1999));
		send_beat(encode_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd2200));
		send_beat(encode_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
	endtask

	// well-formed register set: seconds bit 7, 12/24-hour mode and century bit random
	function automatic logic [55:0] random_clock_regs();
		logic [7:0] sec_b;
		logic [7:0] min_b;
		logic [7:0] hr_b;
		logic [7:0] mo_b;
		logic [7:0] h12;
		sec_b = to_bcd($urandom_range(59));
		sec_b[7] = 1'($urandom_range(1));
		min_b = to_bcd($urandom_range(59));
		if ($urandom_range(1)) begin
			h12 = to_bcd($urandom_range(12, 1));
			hr_b = {1'b0, 1'b1, 1'($urandom_range(1)), h12[4:0]};
		end else begin
			hr_b = to_bcd($urandom_range(23));
		end
		mo_b = to_bcd($urandom_range(12, 1));
		mo_b[7] = 1'($urandom_range(1));
		return {to_bcd($urandom_range(99)), mo_b, to_bcd($urandom_range(31, 1)),
			to_bcd($urandom_range(7, 1)), hr_b, min_b, sec_b};
	endfunction

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		rtcc_pkg::req_t item;
		int             pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				item = decode_item(random_raw());
			end else if (pick < 50) begin
				item = decode_item(random_clock_regs());
			end else begin
				item = encode_item(8'($urandom_range(59)), 8'($urandom_range(59)),
					8'($urandom_range(23)), 8'($urandom_range(7, 1)),
					8'($urandom_range(31, 1)), 8'($urandom_range(12, 1)),
					16'($urandom_range(2199, 2000)));
				// broken dates: some fields replaced by anything the width allows
				if (pick >= 85) begin
					if ($urandom_range(3) == 0) item.set_seconds = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_minutes = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_hours = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_weekday = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_day = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_month = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) item.set_year = 16'($urandom_range(65535));
				end
			end
			send_beat(item);
		end
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 23;
		recv_idle_pct = 85;
		test_decode_fields();
		test_twelve_hour();
		test_encode_limits();
		test_encode_rejects();
		test_random_traffic(23, 85, PHASE_ITEMS);
		test_random_traffic(85, 23, PHASE_ITEMS);
		test_random_traffic(0, 0, PHASE_ITEMS);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
